// ===== rtl/pcl_pkg.sv =====
// shared types, codes and defaults for the positional circular list
`default_nettype none
package pcl_pkg;

	localparam int DEF_CAPACITY   = 32;
	localparam int DEF_DATA_WIDTH = 32;

	localparam logic [3:0] OP_PUSH_FRONT = 4'd0;
	localparam logic [3:0] OP_PUSH_BACK  = 4'd1;
	localparam logic [3:0] OP_INSERT     = 4'd2;
	localparam logic [3:0] OP_POP_FRONT  = 4'd3;
	localparam logic [3:0] OP_POP_BACK   = 4'd4;
	localparam logic [3:0] OP_ERASE      = 4'd5;
	localparam logic [3:0] OP_COUNT      = 4'd6;
	localparam logic [3:0] OP_READ_HEAD  = 4'd7;
	localparam logic [3:0] OP_CLEAR      = 4'd8;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_BADPOS = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	typedef struct packed {
		logic [3:0]         operation;
		logic signed [31:0] value;
		logic [5:0]         position;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] head_value;
		logic [5:0]         match_count;
		logic [5:0]         length;
	} out_item_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic rd;
		logic wr;
		logic fin;
	} ctl_cmd_t;

	typedef struct packed {
		logic loop_done;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/positional_circular_list.sv =====
// top level of the positional circular list
//
//   channel  | direction | handshake            | payload
//   in       | input     | in_valid / in_stall  | in_data  (operation, value, position)
//   out      | output    | out_valid / out_stall| out_data (status, head_value, match_count, length)
//
// each request is loaded and executed; push, pop, clear and errors then register the result
// read head, count, insert, erase walk elements first (store read port), a read and a write step each
// one request in flight; the next is taken while the result waits for transfer
// reset empties the list at once; store contents are left as they are
// a stalled result holds its register and the sequencer waits before loading another
`default_nettype none
module positional_circular_list #(
	parameter int CAPACITY   = pcl_pkg::DEF_CAPACITY,
	parameter int DATA_WIDTH = pcl_pkg::DEF_DATA_WIDTH
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  pcl_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  wire                out_stall,
	output pcl_pkg::out_item_t out_data
);

	pcl_pkg::ctl_cmd_t cmd;
	pcl_pkg::dp_stat_t stat;

	pcl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	pcl_dp #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (out_data)
	);

endmodule
`default_nettype wire

// ===== rtl/pcl_ctrl.sv =====
// sequencer for request load, element loop and result hand-off
`default_nettype none
module pcl_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  wire               out_stall,
	output pcl_pkg::ctl_cmd_t cmd,
	input  pcl_pkg::dp_stat_t stat
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_WR   = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_RD;
			end
			S_RD: begin
				if (stat.loop_done) begin
					state_d = S_FIN;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_WR;
				end
			end
			S_WR: begin
				cmd.wr  = 1'b1;
				state_d = S_RD;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// a result never overwrites one still waiting for transfer
	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> (!out_valid_q || !out_stall))
		else $error("result loaded over a pending transfer");

	a_load_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_EXEC))
		else $error("accepted request not executed");

	a_fin_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> out_valid)
		else $error("finished request gave no result");

endmodule
`default_nettype wire

// ===== rtl/pcl_dp.sv =====
// list store, pointers, element loop datapath and result register
`default_nettype none
module pcl_dp #(
	parameter int CAPACITY   = pcl_pkg::DEF_CAPACITY,
	parameter int DATA_WIDTH = pcl_pkg::DEF_DATA_WIDTH
) (
	input  wire                clk,
	input  wire                arst_n,
	input  pcl_pkg::in_item_t  in_data,
	input  pcl_pkg::ctl_cmd_t  cmd,
	output pcl_pkg::dp_stat_t  stat,
	output pcl_pkg::out_item_t out_data
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int MW = ((CW > 6) ? CW : 6) + 1;

	localparam logic [1:0] K_NONE = 2'd0;
	localparam logic [1:0] K_INS  = 2'd1;
	localparam logic [1:0] K_ERA  = 2'd2;
	localparam logic [1:0] K_READ = 2'd3;

	logic [DATA_WIDTH-1:0] mem [CAPACITY];
	logic [DATA_WIDTH-1:0] rdata_q;

	logic [3:0]            op_q;
	logic [DATA_WIDTH-1:0] word_q;
	logic [5:0]            pos_q;
	logic [AW-1:0]         head_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         idx_q, end_q;
	logic                  up_q;
	logic [1:0]            kind_q;
	logic [1:0]            status_q;
	logic [31:0]           headv_q;
	logic [CW-1:0]         match_q;
	pcl_pkg::out_item_t    out_q;

	logic [DATA_WIDTH+31:0] word_ext;
	logic [DATA_WIDTH+31:0] rd_sext;
	logic                   full, empty;
	logic [MW-1:0]          pos_m, count_m;
	logic                   we;
	logic [AW-1:0]          waddr, raddr;
	logic [DATA_WIDTH-1:0]  wdata;
	logic [AW-1:0]          head_dec, head_inc;
	logic [CW-1:0]          ridx, len_fin;
	logic [CW+5:0]          len_ext, match_ext;

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] i);
		logic [CW:0] s;
		s = (CW+1)'(h) + (CW+1)'(i);
		if (s >= (CW+1)'(CAPACITY)) begin
			s = s - (CW+1)'(CAPACITY);
		end
		return s[AW-1:0];
	endfunction

	assign word_ext  = {{DATA_WIDTH{1'b0}}, in_data.value};
	assign rd_sext   = {{32{rdata_q[DATA_WIDTH-1]}}, rdata_q};
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);
	assign pos_m     = MW'(pos_q);
	assign count_m   = MW'(count_q);
	assign head_dec  = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - 1'b1;
	assign head_inc  = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + 1'b1;
	assign stat.loop_done = (idx_q == end_q);

	// shifting loops read one neighbor away from the slot they write
	always_comb begin
		case (kind_q)
			K_INS:   ridx = idx_q - 1'b1;
			K_ERA:   ridx = idx_q + 1'b1;
			default: ridx = idx_q;
		endcase
	end
	assign raddr = phys(head_q, ridx);

	always_comb begin
		we    = 1'b0;
		waddr = phys(head_q, idx_q);
		wdata = rdata_q;
		if (cmd.exec && !full) begin
			if (op_q == pcl_pkg::OP_PUSH_FRONT ||
			    (op_q == pcl_pkg::OP_INSERT && pos_q == '0 && count_m != '0)) begin
				we    = 1'b1;
				waddr = head_dec;
				wdata = word_q;
			end else if (op_q == pcl_pkg::OP_PUSH_BACK ||
			             (op_q == pcl_pkg::OP_INSERT && pos_m >= count_m)) begin
				we    = 1'b1;
				waddr = phys(head_q, count_q);
				wdata = word_q;
			end
		end else if (cmd.wr && (kind_q == K_INS || kind_q == K_ERA)) begin
			we = 1'b1;
		end else if (cmd.fin && kind_q == K_INS) begin
			we    = 1'b1;
			wdata = word_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= mem[raddr];
		end
	end

	always_comb begin
		case (kind_q)
			K_INS:   len_fin = count_q + 1'b1;
			K_ERA:   len_fin = count_q - 1'b1;
			default: len_fin = count_q;
		endcase
	end
	assign len_ext   = {6'b0, len_fin};
	assign match_ext = {6'b0, match_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			end_q   <= '0;
			up_q    <= 1'b1;
			kind_q  <= K_NONE;
		end else begin
			if (cmd.load) begin
				kind_q <= K_NONE;
			end
			if (cmd.exec) begin
				idx_q <= '0;
				end_q <= '0;
				up_q  <= 1'b1;
				unique case (op_q) inside
					pcl_pkg::OP_PUSH_FRONT, pcl_pkg::OP_PUSH_BACK: begin
						if (!full) begin
							count_q <= count_q + 1'b1;
							if (op_q == pcl_pkg::OP_PUSH_FRONT) begin
								head_q <= head_dec;
							end
						end
					end
					pcl_pkg::OP_INSERT: begin
						if (!full) begin
							if (pos_m >= count_m) begin
								count_q <= count_q + 1'b1;
							end else if (pos_q == '0) begin
								head_q  <= head_dec;
								count_q <= count_q + 1'b1;
							end else begin
								idx_q  <= count_q;
								end_q  <= CW'(pos_q);
								up_q   <= 1'b0;
								kind_q <= K_INS;
							end
						end
					end
					pcl_pkg::OP_POP_FRONT: begin
						if (!empty) begin
							head_q  <= head_inc;
							count_q <= count_q - 1'b1;
						end
					end
					pcl_pkg::OP_POP_BACK: begin
						if (!empty) begin
							count_q <= count_q - 1'b1;
						end
					end
					pcl_pkg::OP_ERASE: begin
						if (!empty) begin
							if (pos_q <= 6'd1) begin
								head_q  <= head_inc;
								count_q <= count_q - 1'b1;
							end else if (pos_m <= count_m) begin
								idx_q  <= CW'(pos_q - 6'd1);
								end_q  <= count_q - 1'b1;
								kind_q <= K_ERA;
							end
						end
					end
					pcl_pkg::OP_COUNT: begin
						end_q  <= count_q;
						kind_q <= K_READ;
					end
					pcl_pkg::OP_READ_HEAD: begin
						if (!empty) begin
							end_q  <= CW'(1);
							kind_q <= K_READ;
						end
					end
					pcl_pkg::OP_CLEAR: count_q <= '0;
					default: ;
				endcase
			end
			if (cmd.wr) begin
				idx_q <= up_q ? idx_q + 1'b1 : idx_q - 1'b1;
			end
			if (cmd.fin) begin
				count_q <= len_fin;
			end
		end
	end

	// request fields, status and read results
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= in_data.operation;
			word_q   <= word_ext[DATA_WIDTH-1:0];
			pos_q    <= in_data.position;
			status_q <= pcl_pkg::ST_OK;
			headv_q  <= '0;
			match_q  <= '0;
		end
		if (cmd.exec) begin
			unique case (op_q) inside
				pcl_pkg::OP_PUSH_FRONT, pcl_pkg::OP_PUSH_BACK, pcl_pkg::OP_INSERT: begin
					if (full) status_q <= pcl_pkg::ST_FULL;
				end
				pcl_pkg::OP_POP_FRONT, pcl_pkg::OP_POP_BACK, pcl_pkg::OP_READ_HEAD: begin
					if (empty) status_q <= pcl_pkg::ST_EMPTY;
				end
				pcl_pkg::OP_ERASE: begin
					if (empty) begin
						status_q <= pcl_pkg::ST_EMPTY;
					end else if (pos_q > 6'd1 && pos_m > count_m) begin
						status_q <= pcl_pkg::ST_BADPOS;
					end
				end
				default: ;
			endcase
		end
		if (cmd.wr && kind_q == K_READ) begin
			if (op_q == pcl_pkg::OP_COUNT) begin
				if (rdata_q == word_q) match_q <= match_q + 1'b1;
			end else begin
				headv_q <= rd_sext[31:0];
			end
		end
		if (cmd.fin) begin
			out_q.status      <= status_q;
			out_q.head_value  <= headv_q;
			out_q.match_count <= match_ext[5:0];
			out_q.length      <= len_ext[5:0];
		end
	end

	assign out_data = out_q;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the positional circular list
`default_nettype none
module testbench;

	localparam int CAP = pcl_pkg::DEF_CAPACITY;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	pcl_pkg::in_item_t in_data;
	logic out_valid;
	logic out_stall;
	pcl_pkg::out_item_t out_data;

	positional_circular_list u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	pcl_pkg::in_item_t request_q[$];
	pcl_pkg::out_item_t expected_q[$];
	logic signed [31:0] shadow_list[$];
	int errors = 0;
	int sent = 0;
	int received = 0;
	int hold_cycles = 0;
	bit quiet_in = 0;
	bit quiet_out = 0;
	bit pause_in = 0;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// predicts the response and updates the shadow list
	function automatic pcl_pkg::out_item_t list_apply(pcl_pkg::in_item_t r);
		pcl_pkg::out_item_t o;
		int n;
		int p;
		o = '0;
		n = shadow_list.size();
		p = r.position;
		case (r.operation) inside
			pcl_pkg::OP_PUSH_FRONT, pcl_pkg::OP_PUSH_BACK, pcl_pkg::OP_INSERT: begin
				if (n >= CAP) o.status = pcl_pkg::ST_FULL;
				else if (r.operation == pcl_pkg::OP_PUSH_FRONT) shadow_list.insert(0, r.value);
				else if (r.operation == pcl_pkg::OP_PUSH_BACK) shadow_list.insert(n, r.value);
				else shadow_list.insert(p < n ? p : n, r.value);
			end
			pcl_pkg::OP_POP_FRONT, pcl_pkg::OP_POP_BACK: begin
				if (n == 0) o.status = pcl_pkg::ST_EMPTY;
				else if (r.operation == pcl_pkg::OP_POP_FRONT) shadow_list.delete(0);
				else shadow_list.delete(n - 1);
			end
			pcl_pkg::OP_ERASE: begin
				if (n == 0) o.status = pcl_pkg::ST_EMPTY;
				else if (p <= 1) shadow_list.delete(0);
				else if (p > n) o.status = pcl_pkg::ST_BADPOS;
				else shadow_list.delete(p - 1);
			end
			pcl_pkg::OP_COUNT: begin
				foreach (shadow_list[i])
					if (shadow_list[i] == r.value) o.match_count++;
			end
			pcl_pkg::OP_READ_HEAD: begin
				if (n == 0) o.status = pcl_pkg::ST_EMPTY;
				else o.head_value = shadow_list[0];
			end
			pcl_pkg::OP_CLEAR: shadow_list.delete();
			default: ;
		endcase
		o.length = 6'(shadow_list.size());
		return o;
	endfunction

	function automatic pcl_pkg::in_item_t make_req(logic [3:0] op, logic signed [31:0] v,
			int p);
		pcl_pkg::in_item_t r;
		r.operation = op;
		r.value = v;
		r.position = p[5:0];
		return r;
	endfunction

	task automatic queue_req(input pcl_pkg::in_item_t r);
		request_q.insert(request_q.size(), r);
	endtask

	// value from a small pool so count finds matches, sometimes fully random
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'h8000_0000 + $urandom_range(0, 1);
			default: return $urandom_range(0, 5) - 2;
		endcase
	endfunction

	function automatic pcl_pkg::in_item_t random_req(int fill_bias);
		logic [3:0] op;
		int w;
		w = $urandom_range(0, 99);
		if (w < fill_bias) op = 4'($urandom_range(0, 2));
		else if (w < 97) op = 4'($urandom_range(3, 8));
		else op = 4'($urandom_range(9, 15));
		if (op == pcl_pkg::OP_CLEAR && $urandom_range(0, 3) != 0) op = pcl_pkg::OP_COUNT;
		return make_req(op, pick_value(), $urandom_range(0, 63));
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_q.insert(expected_q.size(), list_apply(in_data));
				sent++;
			end
			if ((in_valid && !in_stall) || !in_valid) begin
				if (request_q.size() != 0 && !pause_in &&
						(quiet_in || $urandom_range(0, 99) >= 11)) begin
					in_valid <= 1'b1;
					in_data <= request_q[0];
					request_q.delete(0);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				received++;
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result %p", $time, out_data);
				end else begin
					pcl_pkg::out_item_t e;
					e = expected_q[0];
					expected_q.delete(0);
					if (out_data.status !== e.status || out_data.head_value !== e.head_value ||
							out_data.match_count !== e.match_count ||
							out_data.length !== e.length) begin
						errors++;
						$display("%0t: mismatch expected %p actual %p", $time, e, out_data);
					end
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !quiet_out && ($urandom_range(0, 99) < 11);
			end
		end
	end

	task automatic wait_drained();
		while (request_q.size() != 0 || in_valid || expected_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;

		// directed: empty-list errors, fill to full, position corners
		queue_req(make_req(pcl_pkg::OP_POP_FRONT, 0, 0));
		queue_req(make_req(pcl_pkg::OP_POP_BACK, 0, 0));
		queue_req(make_req(pcl_pkg::OP_ERASE, 0, 3));
		queue_req(make_req(pcl_pkg::OP_READ_HEAD, 0, 0));
		queue_req(make_req(pcl_pkg::OP_COUNT, 0, 0));
		queue_req(make_req(pcl_pkg::OP_CLEAR, 0, 0));
		queue_req(make_req(pcl_pkg::OP_PUSH_FRONT, 32'sh7fff_ffff, 0));
		queue_req(make_req(pcl_pkg::OP_PUSH_BACK, 32'sh8000_0000, 0));
		queue_req(make_req(pcl_pkg::OP_INSERT, -1, 0));
		queue_req(make_req(pcl_pkg::OP_INSERT, 0, 63));
		queue_req(make_req(pcl_pkg::OP_INSERT, 5, 2));
		queue_req(make_req(pcl_pkg::OP_READ_HEAD, 0, 0));
		queue_req(make_req(pcl_pkg::OP_COUNT, -1, 0));
		queue_req(make_req(pcl_pkg::OP_ERASE, 0, 0));
		queue_req(make_req(pcl_pkg::OP_ERASE, 0, 1));
		queue_req(make_req(pcl_pkg::OP_ERASE, 0, 9));
		queue_req(make_req(pcl_pkg::OP_ERASE, 0, 3));
		queue_req(make_req(pcl_pkg::OP_ERASE, 0, 2));
		queue_req(make_req(4'd15, -1, 63));
		queue_req(make_req(4'd9, 0, 0));
		queue_req(make_req(pcl_pkg::OP_CLEAR, 0, 0));
		for (int i = 0; i < CAP; i++)
			queue_req(make_req(pcl_pkg::OP_PUSH_BACK, i[0] ? -1 : 32'sh5555_aaaa, 0));
		queue_req(make_req(pcl_pkg::OP_PUSH_FRONT, 1, 0));
		queue_req(make_req(pcl_pkg::OP_INSERT, 1, 32));
		queue_req(make_req(pcl_pkg::OP_COUNT, -1, 0));
		queue_req(make_req(pcl_pkg::OP_ERASE, 0, 32));
		queue_req(make_req(pcl_pkg::OP_ERASE, 0, 32));
		queue_req(make_req(pcl_pkg::OP_ERASE, 0, 33));

		// long receiver hold-off while the sender keeps offering
		quiet_in = 1;
		hold_cycles = 300;
		wait_drained();
		quiet_in = 0;

		// random phase with a bias toward filling, then toward emptying
		for (int i = 0; i < 600; i++) begin
			queue_req(random_req(i < 300 ? 60 : 35));
			if (i == 200) begin
				// sender pause until everything is back
				wait_drained();
				pause_in = 1;
				repeat (20) @(posedge clk);
				pause_in = 0;
				quiet_in = 1;
				quiet_out = 1;
			end
			if (i == 300) begin
				quiet_in = 0;
				quiet_out = 0;
			end
			if (request_q.size() > 40) @(posedge clk);
			while (request_q.size() > 40) @(posedge clk);
		end
		wait_drained();
		repeat (50) @(posedge clk);
		$display("covered %0d requests and %0d responses across empty, full and mid fill",
			sent, received);
		if (errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

	initial begin
		#3000000;
		$display("timeout waiting on responses");
		$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire

// ===== positional_circular_list.f =====
rtl/pcl_pkg.sv
rtl/pcl_ctrl.sv
rtl/pcl_dp.sv
rtl/positional_circular_list.sv
tb/testbench.sv
